@@ sv/xtea_block_cipher_unit_assert.svh @@
// Assertion macros shared by the cipher RTL modules.
`ifndef XTEA_BLOCK_CIPHER_UNIT_ASSERT_SVH
`define XTEA_BLOCK_CIPHER_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is low.
`define XBC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define XBC_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ sv/xbc_pkg.sv @@
// Package with the cipher constants, types and the per-stage sum function.
`default_nettype none

package xbc_pkg;

  localparam int unsigned ROUNDS    = 32;
  localparam int unsigned STAGES    = 2 * ROUNDS;
  localparam int unsigned WORD_W    = 32;
  localparam int unsigned KEY_WORDS = 4;
  localparam int unsigned CFG_IDX_W = 8;
  localparam logic [WORD_W-1:0] DELTA = 32'h9e37_79b9;

  typedef logic [WORD_W-1:0] word_t;
  typedef logic [KEY_WORDS-1:0][WORD_W-1:0] key_set_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_KEY_ZERO  = 8'd0,
    REG_KEY_ONE   = 8'd1,
    REG_KEY_TWO   = 8'd2,
    REG_KEY_THREE = 8'd3
  } cfg_reg_t;

  typedef enum logic {
    CMD_ENCRYPT = 1'b0,
    CMD_DECRYPT = 1'b1
  } cmd_t;

  typedef struct packed {
    logic  valid;
    logic  cmd;
    word_t y;
    word_t z;
  } item_t;

  // Running sum seen by half-round stage s (stage 0 is the first).
  function automatic word_t xbc_stage_sum(int unsigned s, logic dec);
    logic [63:0] prod;
    int unsigned k;
    k = (s + 1) >> 1;
    if (dec) begin
      k = ROUNDS - k;
    end
    prod = 64'(DELTA) * 64'(k);
    return prod[WORD_W-1:0];
  endfunction

endpackage

`default_nettype wire

@@ sv/xbc_half_round.sv @@
// One registered half-round of the cipher: updates one word of the block.
`default_nettype none

module xbc_half_round
  import xbc_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     even_stage,
  input  wire word_t    enc_sum,
  input  wire word_t    dec_sum,
  input  wire key_set_t keys,
  input  wire item_t    item_in,
  output item_t         item_out
);

  `include "xtea_block_cipher_unit_assert.svh"

  item_t       item_r;
  item_t       item_nxt;
  logic        upd_y;
  word_t       sum;
  word_t       x;
  word_t       tgt;
  word_t       mix;
  logic [1:0]  kidx;

  always_comb begin
    // Encrypt updates y on even stages; decrypt runs the steps mirrored.
    upd_y = even_stage ^ item_in.cmd;
    sum   = (item_in.cmd == CMD_DECRYPT) ? dec_sum : enc_sum;
    x     = upd_y ? item_in.z : item_in.y;
    tgt   = upd_y ? item_in.y : item_in.z;
    kidx  = upd_y ? sum[1:0] : sum[12:11];
    mix   = ((x << 4) ^ (x >> 5)) + (x ^ sum) + keys[kidx];
    item_nxt = item_in;
    if (upd_y) begin
      item_nxt.y = (item_in.cmd == CMD_DECRYPT) ? (tgt - mix) : (tgt + mix);
    end else begin
      item_nxt.z = (item_in.cmd == CMD_DECRYPT) ? (tgt - mix) : (tgt + mix);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_r.valid <= 1'b0;
    end else begin
      item_r.valid <= item_in.valid;
    end
    item_r.cmd <= item_nxt.cmd;
    item_r.y   <= item_nxt.y;
    item_r.z   <= item_nxt.z;
  end

  assign item_out = item_r;

  `XBC_ASSERT_NXT(a_valid_follows, item_in.valid, item_r.valid, "stage valid lost")
  `XBC_ASSERT_NXT(a_cmd_carried, item_in.valid, item_r.cmd == $past(item_in.cmd),
    "command changed in stage")
  `XBC_ASSERT_NXT(a_one_word_only, item_in.valid,
    (item_r.y == $past(item_in.y)) || (item_r.z == $past(item_in.z)),
    "both words changed in one half-round")

endmodule

`default_nettype wire

@@ sv/xtea_block_cipher_unit.sv @@
// Top level of the pipelined XTEA-style block cipher unit.
//
// Usage:
//   Request channel: drive in_cmd (0 encrypt, 1 decrypt), in_first_word and
//   in_second_word and pulse start. A request is taken at every rising edge
//   with start high and busy low; busy never rises, so a new request may be
//   issued every cycle.
//   Result channel: out_valid is high for exactly one cycle while
//   out_first_word / out_second_word carry the result. Results come back in
//   request order; the receiver cannot stall, so none are held.
//   Each request passes one register stage per half-round, 32 rounds of
//   two half-rounds. Throughput: one block per cycle, set by the fully
//   unrolled 64-stage half-round pipeline.
//   Key: four 32-bit key words written through cfg_we / cfg_index /
//   cfg_wdata; index 0..3 selects the word, higher indexes are ignored.
//   Change keys only while no requests are in flight.
//   Reset (rst_n low, synchronous) clears the key words and drops every
//   request in flight; no result appears for them.
`default_nettype none

module xtea_block_cipher_unit
  import xbc_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 start,
  output logic                      busy,
  input  wire logic                 in_cmd,
  input  wire logic [WORD_W-1:0]    in_first_word,
  input  wire logic [WORD_W-1:0]    in_second_word,
  output logic                      out_valid,
  output logic [WORD_W-1:0]         out_first_word,
  output logic [WORD_W-1:0]         out_second_word,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [WORD_W-1:0]    cfg_wdata
);

  `include "xtea_block_cipher_unit_assert.svh"

  key_set_t keys_r;
  key_set_t keys_nxt;
  item_t    pipe [STAGES+1];
  logic     accept;

  // The pipeline never stalls, so requests are always taken.
  assign busy   = 1'b0;
  assign accept = start && !busy;

  // Key registers: one word per write, unknown indexes dropped.
  always_comb begin
    keys_nxt = keys_r;
    if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_KEY_ZERO:  keys_nxt[0] = cfg_wdata;
        REG_KEY_ONE:   keys_nxt[1] = cfg_wdata;
        REG_KEY_TWO:   keys_nxt[2] = cfg_wdata;
        REG_KEY_THREE: keys_nxt[3] = cfg_wdata;
        default:       keys_nxt    = keys_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      keys_r <= '0;
    end else begin
      keys_r <= keys_nxt;
    end
  end

  // Stage 0 input comes straight from the request ports.
  always_comb begin
    pipe[0].valid = accept;
    pipe[0].cmd   = in_cmd;
    pipe[0].y     = in_first_word;
    pipe[0].z     = in_second_word;
  end

  // One half-round per register stage; the sums are fixed per stage.
  for (genvar s = 0; s < STAGES; s++) begin : g_stage
    localparam word_t ENC_SUM = xbc_stage_sum(s, 1'b0);
    localparam word_t DEC_SUM = xbc_stage_sum(s, 1'b1);

    xbc_half_round u_half (
      .clk        (clk),
      .rst_n      (rst_n),
      .even_stage ((s % 2) == 0),
      .enc_sum    (ENC_SUM),
      .dec_sum    (DEC_SUM),
      .keys       (keys_r),
      .item_in    (pipe[s]),
      .item_out   (pipe[s+1])
    );
  end

  assign out_valid       = pipe[STAGES].valid;
  assign out_first_word  = pipe[STAGES].y;
  assign out_second_word = pipe[STAGES].z;

  `XBC_ASSERT_IMP(a_no_spurious_result, out_valid, $past(accept, STAGES),
    "result without matching request")
  `XBC_ASSERT_IMP(a_request_returns, accept, ##STAGES out_valid,
    "request produced no result")
  `XBC_ASSERT_NXT(a_bad_index_ignored, cfg_we && (cfg_index > REG_KEY_THREE),
    keys_r == $past(keys_r), "write to unknown index changed a key")

endmodule

`default_nettype wire

@@ verif/xtea_block_cipher_unit_tb.sv @@
// Self-checking testbench for the pipelined XTEA-style block cipher unit.
`timescale 1ns / 100ps

module xtea_block_cipher_unit_tb
  import xbc_pkg::*;
();

  // Register indexes outside the key file; writes there must change nothing.
  localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED_LO = 8'd4;
  localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED_HI = 8'hff;

  // Settle time after the last result.
  localparam int unsigned DRAIN_CYCLES = 2 * STAGES;
  localparam int unsigned RUN_LIMIT_NS = 2_000_000;

  typedef struct {
    cmd_t  cmd;
    word_t y;
    word_t z;
  } block_req_t;

  typedef struct {
    word_t y;
    word_t z;
  } block_res_t;

  logic                 clk;
  logic                 rst_n;
  logic                 start;
  logic                 busy;
  logic                 in_cmd;
  logic [WORD_W-1:0]    in_first_word;
  logic [WORD_W-1:0]    in_second_word;
  logic                 out_valid;
  logic [WORD_W-1:0]    out_first_word;
  logic [WORD_W-1:0]    out_second_word;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [WORD_W-1:0]    cfg_wdata;

  block_req_t  pending_blocks[$];   // requests not yet taken by the block
  block_res_t  expected_blocks[$];  // predicted results, oldest first
  key_set_t    key_mirror;          // key file as seen by the block
  key_set_t    key_now;             // key file as the stimulus writes it
  int unsigned idle_pct;            // chance, in percent, that the sender idles
  logic        req_stalled;         // request was offered but held off by busy
  int unsigned fail_count;

  xtea_block_cipher_unit u_top (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_cmd         (in_cmd),
    .in_first_word  (in_first_word),
    .in_second_word (in_second_word),
    .out_valid      (out_valid),
    .out_first_word (out_first_word),
    .out_second_word(out_second_word),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata)
  );

  // One half-round mix term, grouped as:
  // ((x << 4) ^ (x >> 5)) + (x ^ sum) + key, all modulo 2^32.
  function automatic word_t round_mix(word_t x, word_t s, word_t k);
    return ((x << 4) ^ (x >> 5)) + (x ^ s) + k;
  endfunction

  // Full transform of one block, all rounds, under the given key file.
  function automatic block_res_t cipher_block(block_req_t req, key_set_t key);
    word_t      y;
    word_t      z;
    word_t      s;
    block_res_t res;
    y = req.y;
    z = req.z;
    if (req.cmd == CMD_ENCRYPT) begin
      s = '0;
      for (int r = 0; r < ROUNDS; r++) begin
        y = y + round_mix(z, s, key[s[1:0]]);
        s = s + DELTA;
        z = z + round_mix(y, s, key[s[12:11]]);
      end
    end else begin
      // Decryption walks the sum back down from delta * rounds.
      s = DELTA * ROUNDS;
      for (int r = 0; r < ROUNDS; r++) begin
        z = z - round_mix(y, s, key[s[12:11]]);
        s = s - DELTA;
        y = y - round_mix(z, s, key[s[1:0]]);
      end
    end
    res.y = y;
    res.z = z;
    return res;
  endfunction

  // Bias random words toward the all-zero and all-one corners.
  function automatic word_t pick_word();
    case ($urandom_range(7))
      0: return '0;
      1: return '1;
      default: return $urandom;
    endcase
  endfunction

  // Free-running clock, 10 ns period.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Request driver. Inputs change on the falling edge so the block sees
  // stable values at the rising edge. A request held off by busy stays up
  // unchanged; otherwise roll the idle dice each cycle and either present
  // the head of the pending queue or drop start.
  always @(negedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else if (!req_stalled) begin
      if (pending_blocks.size() != 0 && $urandom_range(99) >= idle_pct) begin
        start          <= 1'b1;
        in_cmd         <= pending_blocks[0].cmd;
        in_first_word  <= pending_blocks[0].y;
        in_second_word <= pending_blocks[0].z;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Monitor. Everything is sampled on the rising edge:
  //   - mirror key writes so predictions use what the block holds,
  //   - check each result strobe against the oldest prediction,
  //   - on an accepted request, predict its result and advance the queue.
  always @(posedge clk) begin
    block_res_t want;
    if (rst_n) begin
      // Writes above the last key index are ignored by the block.
      if (cfg_we && cfg_index <= REG_KEY_THREE) begin
        key_mirror[cfg_index[1:0]] = cfg_wdata;
      end
      if (out_valid === 1'b1) begin
        if (expected_blocks.size() == 0) begin
          $display("%0t: result with no request outstanding, actual %h %h",
                   $time, out_first_word, out_second_word);
          fail_count++;
        end else begin
          want = expected_blocks.pop_front();
          if (out_first_word !== want.y) begin
            $display("%0t: out_first_word mismatch, expected %h, actual %h",
                     $time, want.y, out_first_word);
            fail_count++;
          end
          if (out_second_word !== want.z) begin
            $display("%0t: out_second_word mismatch, expected %h, actual %h",
                     $time, want.z, out_second_word);
            fail_count++;
          end
        end
      end
      if (start && !busy) begin
        expected_blocks.push_back(cipher_block(pending_blocks[0], key_mirror));
        void'(pending_blocks.pop_front());
      end
      req_stalled <= start && busy;
    end else begin
      req_stalled <= 1'b0;
    end
  end

  // Register write on the configuration port, one cycle wide.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input word_t data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    if (idx <= REG_KEY_THREE) begin
      key_now[idx[1:0]] = data;
    end
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic write_keys(input word_t k0, input word_t k1, input word_t k2,
                            input word_t k3);
    write_reg(REG_KEY_ZERO, k0);
    write_reg(REG_KEY_ONE, k1);
    write_reg(REG_KEY_TWO, k2);
    write_reg(REG_KEY_THREE, k3);
  endtask

  task automatic queue_block(input cmd_t cmd, input word_t y, input word_t z);
    block_req_t req;
    req.cmd = cmd;
    req.y   = y;
    req.z   = z;
    pending_blocks.push_back(req);
  endtask

  // Queue one block in both directions.
  task automatic queue_both(input word_t y, input word_t z);
    queue_block(CMD_ENCRYPT, y, z);
    queue_block(CMD_DECRYPT, y, z);
  endtask

  // Hold until every request is taken and every result has come back.
  // Polled on the falling edge, away from the monitor's updates.
  task automatic drain();
    while (pending_blocks.size() != 0 || expected_blocks.size() != 0) begin
      @(negedge clk);
    end
  endtask

  // Random traffic: one draw in four makes an encrypt-then-decrypt pair where the
  // second request carries the predicted ciphertext, so the pipeline must
  // really invert itself; the rest is random blocks in either direction.
  task automatic random_phase(input int unsigned pct, input int unsigned count);
    int unsigned queued;
    block_req_t  plain;
    block_res_t  ct;
    idle_pct = pct;
    queued   = 0;
    while (queued < count) begin
      if ($urandom_range(3) == 0) begin
        plain.cmd = CMD_ENCRYPT;
        plain.y   = pick_word();
        plain.z   = pick_word();
        ct        = cipher_block(plain, key_now);
        queue_block(CMD_ENCRYPT, plain.y, plain.z);
        queue_block(CMD_DECRYPT, ct.y, ct.z);
        queued += 2;
      end else begin
        queue_block(cmd_t'($urandom_range(1)), pick_word(), pick_word());
        queued++;
      end
    end
    drain();
  endtask

  // Main sequence: reset, directed corners, then random phases under
  // several key settings and idle rates.
  initial begin
    rst_n          = 1'b0;
    start          = 1'b0;
    in_cmd         = 1'b0;
    in_first_word  = '0;
    in_second_word = '0;
    cfg_we         = 1'b0;
    cfg_index      = '0;
    cfg_wdata      = '0;
    key_mirror     = '0;
    key_now        = '0;
    idle_pct       = 0;
    req_stalled    = 1'b0;
    fail_count     = 0;

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: word extremes both ways under the reset key (all zero).
    queue_both('0, '0);
    queue_both('1, '1);
    queue_both('0, '1);
    queue_both('1, '0);
    queue_both(32'h8000_0000, 32'h0000_0001);
    queue_both(32'haaaa_aaaa, 32'h5555_5555);
    drain();

    // All-ones key, then writes to unmapped indexes with different data:
    // those must leave the key file alone.
    write_keys('1, '1, '1, '1);
    write_reg(REG_UNMAPPED_LO, '0);
    write_reg(REG_UNMAPPED_HI, 32'h0123_4567);
    queue_both('0, '0);
    queue_both('1, '1);
    queue_both(32'h0000_0001, 32'h8000_0000);
    queue_both($urandom, $urandom);
    drain();

    // Random phases: no idling, heavy idling, light idling, across
    // random and extreme key patterns.
    write_keys($urandom, $urandom, $urandom, $urandom);
    random_phase(0, 210);
    write_keys('0, '1, '0, '1);
    random_phase(81, 210);
    write_keys($urandom, $urandom, $urandom, $urandom);
    random_phase(30, 210);
    write_keys('1, '0, 32'h8000_0000, 32'h0000_0001);
    random_phase(0, 210);
    write_reg(REG_KEY_TWO, $urandom);
    write_reg(REG_KEY_ZERO, $urandom);
    random_phase(81, 210);

    // Let the pipeline settle so any stray result is caught.
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("xtea_block_cipher_unit_tb passed");
    end else begin
      $display("xtea_block_cipher_unit_tb failed");
    end
    $finish;
  end

  // Watchdog: a hung handshake or lost result ends the run here.
  initial begin
    #(RUN_LIMIT_NS);
    $display("%0t: run did not finish in time", $time);
    $display("xtea_block_cipher_unit_tb failed");
    $finish;
  end

endmodule
